@@ design/sktt_pkg.sv @@
// ---------------------------------------------------------------------------
// sktt_pkg - shared types and constants of the key sorting unit
// Record layout, cell link and control types, and controller states.
// ---------------------------------------------------------------------------
package sktt_pkg;

	localparam int SKTT_CAPACITY = 64;
	localparam int KEY_W         = 64;
	localparam int TAG_W         = 32;
	localparam int REC_W         = KEY_W + 2 * TAG_W;

	// one stored record, key in the low bits as on the stream
	typedef struct packed {
		logic [TAG_W-1:0] second_tag;
		logic [TAG_W-1:0] first_tag;
		logic [KEY_W-1:0] sort_key;
	} rec_t;

	// what a cell shows to its neighbours
	typedef struct packed {
		rec_t rec;
		logic valid;
		logic gt;     // holds a key strictly greater than the incoming one
	} link_t;

	// common control broadcast along the chain
	typedef struct packed {
		logic insert; // place the incoming record
		logic pop;    // shift every cell one place towards the head
	} ctl_t;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;

endpackage

@@ design/sktt_cell.sv @@
// ---------------------------------------------------------------------------
// sktt_cell - one place of the insertion chain
// Holds a record, compares it with the incoming key and moves data sideways.
// ---------------------------------------------------------------------------
module sktt_cell
	import sktt_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  ctl_t  ctl,
	input  rec_t  new_rec,
	input  link_t left,
	input  link_t right,
	output link_t here
);

	rec_t rec_q;
	logic valid_q;
	logic gt;

	assign gt = valid_q && ($signed(rec_q.sort_key) > $signed(new_rec.sort_key));

	assign here.rec   = rec_q;
	assign here.valid = valid_q;
	assign here.gt    = gt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.pop) begin
			valid_q <= right.valid;
		end else if (ctl.insert && !valid_q) begin
			valid_q <= left.valid;
		end
	end

	// payload: take the right neighbour on pop; on insert open a gap or take the new record
	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			rec_q <= right.rec;
		end else if (ctl.insert && (gt || !valid_q)) begin
			if (left.gt) begin
				rec_q <= left.rec;
			end else begin
				rec_q <= new_rec;
			end
		end
	end

endmodule

@@ design/sort_keys_with_two_tags_unit.sv @@
// ---------------------------------------------------------------------------
// sort_keys_with_two_tags_unit - stable record sorter on an insertion chain
// Collects records, then streams them out in ascending signed key order.
// ---------------------------------------------------------------------------
// Records (a signed 64-bit key with two signed 32-bit tags) enter one per
// cycle while loading; each is placed at once in a chain of CAPACITY cells
// that keeps the set sorted, a new record landing after every stored record
// whose key is less than or equal to its own, so equal keys leave in arrival
// order. A request with tlast closes the set: s_axis_tready then drops and
// the chain drains through its head cell, one result per cycle while
// m_axis_tready is high. The last result carries tlast. A record that
// arrives while all cells are full (the closing one included) is dropped,
// and every result of that set carries tuser = 1. The head cell is itself
// the output register. After the final result is taken the next set may
// start in the following cycle.
module sort_keys_with_two_tags_unit
	import sktt_pkg::*;
#(
	parameter int CAPACITY = SKTT_CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	// sort_key[63:0], first_tag[95:64], second_tag[127:96]
	input  logic [REC_W-1:0]   s_axis_tdata,
	input  logic               s_axis_tlast,   // last_record
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// sorted_key[63:0], sorted_first_tag[95:64], sorted_second_tag[127:96]
	output logic [REC_W-1:0]   m_axis_tdata,
	output logic               m_axis_tlast,   // final_result
	output logic               m_axis_tuser    // overflowed
);

	state_t state_q, state_nxt;
	logic   overflow_q;
	logic   in_fire, out_fire, full, drop;
	ctl_t   ctl;
	rec_t   new_rec;
	link_t  links [CAPACITY];
	link_t  head_left, tail_right;
	logic [CAPACITY-1:0] valid_vec;

	assign new_rec  = rec_t'(s_axis_tdata);
	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;
	assign full     = links[CAPACITY-1].valid;
	assign drop     = in_fire && full;

	assign ctl.insert = in_fire && !full;
	assign ctl.pop    = out_fire;

	// the head sees an always-valid, never-greater neighbour; the tail sees none
	assign head_left  = '{rec: '0, valid: 1'b1, gt: 1'b0};
	assign tail_right = '{rec: '0, valid: 1'b0, gt: 1'b0};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		sktt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.new_rec (new_rec),
			.left    ((i == 0) ? head_left : links[(i == 0) ? 0 : i - 1]),
			.right   ((i == CAPACITY - 1) ? tail_right
			          : links[(i == CAPACITY - 1) ? i : i + 1]),
			.here    (links[i])
		);
		assign valid_vec[i] = links[i].valid;
	end

	// next state: load until the closing request, drain until the last result
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_fire && s_axis_tlast) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (out_fire && !links[1].valid) begin
					state_nxt = ST_LOAD;
				end
			end
			default: state_nxt = ST_LOAD;
		endcase
	end

	// outputs: the head cell is presented directly
	always_comb begin
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;
		case (state_q)
			ST_LOAD:  s_axis_tready = 1'b1;
			ST_DRAIN: m_axis_tvalid = links[0].valid;
			default: begin
				s_axis_tready = 1'b0;
				m_axis_tvalid = 1'b0;
			end
		endcase
	end

	assign m_axis_tdata = links[0].rec;
	assign m_axis_tlast = !links[1].valid;
	assign m_axis_tuser = overflow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	// remember a dropped record until the set has fully left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overflow_q <= 1'b0;
		end else if (out_fire && !links[1].valid) begin
			overflow_q <= 1'b0;
		end else if (drop) begin
			overflow_q <= 1'b1;
		end
	end

`ifndef SYNTHESIS
	// occupied cells always form a prefix of the chain
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec & (valid_vec + 1'b1)) == '0)
		else $error("chain occupancy is not a prefix");

	// while draining the head always holds a record
	a_drain_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> links[0].valid)
		else $error("draining with an empty head cell");

	// a dropped record marks the set as overflowed
	a_drop_flag: assert property (@(posedge clk) disable iff (!arst_n)
		drop |=> overflow_q)
		else $error("dropped record did not set overflow");

	// after the final result the chain is empty and loading resumes
	a_final_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && m_axis_tlast) |=> (s_axis_tready && valid_vec == '0 && !overflow_q))
		else $error("set not cleared after its final result");
`endif

endmodule

@@ test/sort_keys_with_two_tags_unit_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sort_keys_with_two_tags_unit_tb - self-checking bench of the record sorter
// Streams sets of keyed records with random gaps on both sides. A tracker
// keeps its own sorted copy of every set and checks each unloaded record,
// its tlast and its overflow flag against it.
// ---------------------------------------------------------------------------
module sort_keys_with_two_tags_unit_tb;
	import sktt_pkg::*;

	localparam logic [KEY_W-1:0] KEY_MAX = 64'h7fff_ffff_ffff_ffff;
	localparam logic [KEY_W-1:0] KEY_MIN = 64'h8000_0000_0000_0000;
	localparam logic [TAG_W-1:0] TAG_MAX = 32'h7fff_ffff;
	localparam logic [TAG_W-1:0] TAG_MIN = 32'h8000_0000;
	localparam int RANDOM_ITEMS = 420;
	localparam int HOLD_CYCLES  = 400;      // long receiver stall
	localparam int SETTLE       = 2 * SKTT_CAPACITY + 20;
	localparam int CYCLE_LIMIT  = 200000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [REC_W-1:0] s_axis_tdata = '0;   // sort_key, first_tag, second_tag
	logic             s_axis_tlast = 1'b0; // last_record
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [REC_W-1:0] m_axis_tdata;        // sorted_key, sorted_first_tag, sorted_second_tag
	logic             m_axis_tlast;        // final_result
	logic             m_axis_tuser;        // overflowed
	int               cycle_count = 0;

	// one record as it should leave the block
	typedef struct {
		rec_t rec;
		bit   fin;
		bit   ovf;
	} sorted_rec_t;

	// Holds the set being collected in sorted order and, once a set is
	// closed, the records still due at the output.
	class sort_tracker;
		rec_t        held[$];
		bit          dropped;
		sorted_rec_t due_sorted[$];
		int          errors;

		function new();
			dropped = 1'b0;
			errors  = 0;
		endfunction

		// place an accepted request, and release the set on its last record
		function void take_record(rec_t r, bit last);
			int          pos;
			sorted_rec_t s;
			if (held.size() < SKTT_CAPACITY) begin
				// walk back past every strictly greater key: equal keys keep arrival order
				pos = held.size();
				while (pos > 0 && $signed(held[pos-1].sort_key) > $signed(r.sort_key))
					pos--;
				held.insert(pos, r);
			end else begin
				dropped = 1'b1;
			end
			if (last) begin
				foreach (held[k]) begin
					s.rec = held[k];
					s.fin = (k == held.size() - 1);
					s.ovf = dropped;
					due_sorted.push_back(s);
				end
				held.delete();
				dropped = 1'b0;
			end
		endfunction

		function void check_sorted(logic [REC_W-1:0] data, logic fin, logic ovf);
			rec_t        got;
			sorted_rec_t want;
			got = data;
			if (due_sorted.size() == 0) begin
				$error("unexpected result: sorted_key %0d", $signed(got.sort_key));
				errors++;
				return;
			end
			want = due_sorted.pop_front();
			if (got.sort_key !== want.rec.sort_key) begin
				$error("sorted_key: expected %0d, got %0d",
					$signed(want.rec.sort_key), $signed(got.sort_key));
				errors++;
			end
			if (got.first_tag !== want.rec.first_tag) begin
				$error("sorted_first_tag: expected %0d, got %0d",
					$signed(want.rec.first_tag), $signed(got.first_tag));
				errors++;
			end
			if (got.second_tag !== want.rec.second_tag) begin
				$error("sorted_second_tag: expected %0d, got %0d",
					$signed(want.rec.second_tag), $signed(got.second_tag));
				errors++;
			end
			if (fin !== want.fin) begin
				$error("final_result: expected %0d, got %0d", want.fin, fin);
				errors++;
			end
			if (ovf !== want.ovf) begin
				$error("overflowed: expected %0d, got %0d", want.ovf, ovf);
				errors++;
			end
		endfunction
	endclass

	sort_tracker tracker = new();

	sort_keys_with_two_tags_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	// Watchdog: abandon the run if the block hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Gap before the next request or result: random-length stretches, mostly
	// busy ones with random idle gaps, the others calm and back to back.
	function automatic int pick_gap(inout int left, inout bit busy);
		if (left == 0) begin
			left = $urandom_range(4, 24);
			busy = ($urandom_range(0, 2) != 0);
		end
		left--;
		return busy ? $urandom_range(0, 11) : 0;
	endfunction

	function automatic rec_t make_rec(logic [KEY_W-1:0] key, logic [TAG_W-1:0] t1,
			logic [TAG_W-1:0] t2);
		rec_t r;
		r.sort_key   = key;
		r.first_tag  = t1;
		r.second_tag = t2;
		return r;
	endfunction

	// Mix full-range keys, a narrow band that forces duplicates, and the extremes.
	function automatic rec_t random_record();
		rec_t r;
		int   pick;
		pick = $urandom_range(0, 9);
		if (pick < 4) begin
			r.sort_key = {$urandom, $urandom};
		end else if (pick < 8) begin
			r.sort_key = 64'($urandom_range(0, 8)) - 64'd4;
		end else begin
			case ($urandom_range(0, 3))
				0: r.sort_key = KEY_MAX;
				1: r.sort_key = KEY_MIN;
				2: r.sort_key = '0;
				default: r.sort_key = '1;
			endcase
		end
		r.first_tag  = ($urandom_range(0, 7) == 0) ? TAG_MIN : $urandom;
		r.second_tag = ($urandom_range(0, 7) == 0) ? TAG_MAX : $urandom;
		return r;
	endfunction

	int  send_left = 0;
	bit  send_busy = 1'b0;

	// Offer one request after a random gap and hold it until accepted.
	task automatic send_record(rec_t r, bit last);
		int gap;
		gap = pick_gap(send_left, send_busy);
		repeat (gap) @(negedge clk) s_axis_tvalid <= 1'b0;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= r;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		tracker.take_record(r, last);
	endtask

	task automatic send_random_set(int size);
		for (int i = 0; i < size; i++)
			send_record(random_record(), i == size - 1);
	endtask

	// Stimulus
	initial begin
		int sent;
		int set_no;
		int size;
		sent   = 0;
		set_no = 0;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// extremes of key and tags, with a repeated minimum key
		send_record(make_rec(KEY_MAX, TAG_MAX, TAG_MIN), 1'b0);
		send_record(make_rec(KEY_MIN, TAG_MIN, TAG_MAX), 1'b0);
		send_record(make_rec('0, '0, '1), 1'b0);
		send_record(make_rec('1, '1, '0), 1'b0);
		send_record(make_rec(64'd1, 32'd1, 32'd1), 1'b0);
		send_record(make_rec(KEY_MIN, 32'd2, 32'd3), 1'b0);
		send_record(make_rec(KEY_MAX, 32'd4, 32'd5), 1'b0);
		send_record(make_rec('0, 32'd6, 32'd7), 1'b1);
		// a set of one record
		send_record(make_rec('1, 32'h1234, 32'h5678), 1'b1);
		// all keys equal: arrival order must survive
		for (int i = 0; i < 5; i++)
			send_record(make_rec(-64'sd7, i, ~i), i == 4);
		// strictly descending keys, each landing at the head
		for (int i = 0; i < 6; i++)
			send_record(make_rec(64'd5 - i, 32'h100 + i, 32'h200 + i), i == 5);

		// Random sets, mostly small; a full set, one that loses its closing
		// record and one that loses many are spread among them.
		while (sent < RANDOM_ITEMS) begin
			case (set_no)
				3:       size = SKTT_CAPACITY;
				7:       size = SKTT_CAPACITY + 1;
				11:      size = SKTT_CAPACITY + 16;
				default: size = $urandom_range(1, 16);
			endcase
			send_random_set(size);
			sent += size;
			set_no++;
		end
		@(negedge clk) s_axis_tvalid <= 1'b0;

		// wait for every due record, then give stray results time to show
		while (tracker.due_sorted.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (tracker.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Receiver: random back-pressure, plus two long holds taken mid-set so
	// the chain stays in unload and the sender is stalled against it.
	initial begin
		int gap;
		int recv_left;
		bit recv_busy;
		int taken;
		int next_hold;
		recv_left = 0;
		recv_busy = 1'b0;
		taken     = 0;
		next_hold = 30;
		wait (arst_n);
		forever begin
			gap = pick_gap(recv_left, recv_busy);
			repeat (gap) @(negedge clk) m_axis_tready <= 1'b0;
			@(negedge clk) m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			tracker.check_sorted(m_axis_tdata, m_axis_tlast, m_axis_tuser);
			taken++;
			if (!m_axis_tlast && taken >= next_hold) begin
				next_hold = (next_hold == 30) ? 300 : 32'h7fff_ffff;
				repeat (HOLD_CYCLES) @(negedge clk) m_axis_tready <= 1'b0;
			end
		end
	end

endmodule
